FILE: rtl/lhp_pkg.sv
// ----------------------------------------------------------------------------
// lhp_pkg
// Shared types, widths and bucket tables for the latency histogram block.
// ----------------------------------------------------------------------------
package lhp_pkg;

    localparam int NUM_BUCKETS = 12;
    localparam int BKT_W       = 4;
    localparam int LAT_W       = 32;
    localparam int FRAC_W      = 20;
    localparam int PCT_W       = 17;

    // stream word widths, rounded up to whole bytes
    localparam int IN_DATA_BITS  = LAT_W + 2 * FRAC_W;
    localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = BKT_W + PCT_W;
    localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

    typedef enum logic {
        REQ_RECORD = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type           req_type;
        logic [LAT_W-1:0]    latency_us;
        logic [FRAC_W-1:0]   frac_num;
        logic [FRAC_W-1:0]   frac_den;
    } t_req;

    typedef struct packed {
        logic [BKT_W-1:0]    bucket_index;
        logic [PCT_W-1:0]    percentile_us;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REC,
        S_SUM,
        S_MUL,
        S_WALK,
        S_DONE
    } t_state;

    // upper bound of each bucket in microseconds
    function automatic logic [PCT_W-1:0] bucket_bound(input logic [BKT_W-1:0] idx);
        logic [PCT_W-1:0] b;
        case (idx)
            4'd0:    b = 17'd50;
            4'd1:    b = 17'd100;
            4'd2:    b = 17'd250;
            4'd3:    b = 17'd500;
            4'd4:    b = 17'd1000;
            4'd5:    b = 17'd2500;
            4'd6:    b = 17'd5000;
            4'd7:    b = 17'd10000;
            4'd8:    b = 17'd25000;
            4'd9:    b = 17'd50000;
            4'd10:   b = 17'd100000;
            default: b = 17'd100001;
        endcase
        return b;
    endfunction

    // first bucket whose bound the sample does not exceed; last one catches the rest
    function automatic logic [BKT_W-1:0] pick_bucket(input logic [LAT_W-1:0] lat);
        logic [BKT_W-1:0] b;
        b = BKT_W'(NUM_BUCKETS - 1);
        for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
            if (lat <= LAT_W'(bucket_bound(BKT_W'(i)))) begin
                b = BKT_W'(i);
            end
        end
        return b;
    endfunction

endpackage

FILE: rtl/lhp_ram.sv
// ----------------------------------------------------------------------------
// lhp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lhp_engine.sv
// ----------------------------------------------------------------------------
// lhp_engine
// Sequencer and datapath: read-modify-write of bucket counters for records,
// two sweeps over the counter RAM (total, then cumulative walk) for queries.
// ----------------------------------------------------------------------------
module lhp_engine import lhp_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    output logic                           o_req_ready,
    input  t_req                           i_req,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output t_result                        o_res,
    output logic                           o_ram_we,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_ram_waddr,
    output logic [COUNT_BITS-1:0]          o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_ram_raddr,
    input  logic [COUNT_BITS-1:0]          i_ram_rdata
);

    localparam int ADDR_W = $clog2(NUM_BUCKETS);
    localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
    localparam int TOT_W  = COUNT_BITS + $clog2(NUM_BUCKETS);
    localparam int PROD_W = TOT_W + FRAC_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BUCKETS - 1);

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_addr, n_addr;
    logic                    r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]       r_rd_idx, n_rd_idx;
    logic                    r_rd_live, n_rd_live;
    logic [NUM_BUCKETS-1:0]  r_valid_bits, n_valid_bits;
    logic [ADDR_W-1:0]       r_bkt, n_bkt;
    logic [FRAC_W-1:0]       r_num, n_num;
    logic [FRAC_W-1:0]       r_den, n_den;
    logic [TOT_W-1:0]        r_total, n_total;
    logic [TOT_W-1:0]        r_cum, n_cum;
    logic                    r_cum_vld, n_cum_vld;
    logic [ADDR_W-1:0]       r_cum_idx, n_cum_idx;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic                    r_prod_vld, n_prod_vld;
    logic [ADDR_W-1:0]       r_prod_idx, n_prod_idx;
    logic [PROD_W-1:0]       r_target, n_target;
    t_result                 r_res, n_res;

    logic                    accept;
    logic                    issue;
    logic                    sum_last;
    logic                    reachable;
    logic                    hit;
    logic [COUNT_BITS-1:0]   rd_count;
    logic [ADDR_W-1:0]       rec_bkt;

    // shared decode
    assign accept    = i_req_valid && (r_state == S_IDLE);
    assign rec_bkt   = ADDR_W'(pick_bucket(i_req.latency_us));
    assign issue     = ((r_state == S_SUM) || (r_state == S_WALK))
                       && (r_addr < CNT_W'(NUM_BUCKETS));
    assign sum_last  = (r_state == S_SUM) && r_rd_vld && (r_rd_idx == LAST_ADDR);
    assign reachable = (r_den != '0) && (r_num <= r_den);
    // cum >= ceil(total*num/den)  <=>  cum*den >= total*num
    assign hit       = (r_state == S_WALK) && r_prod_vld && (r_prod >= r_target);
    // entries never written since reset read as zero
    assign rd_count  = r_rd_live ? i_ram_rdata : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.req_type == REQ_RECORD) ? S_REC : S_SUM;
                end
            end
            S_REC:  n_state = S_DONE;
            S_SUM: begin
                if (sum_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = ((r_total == '0) || !reachable) ? S_DONE : S_WALK;
            end
            S_WALK: begin
                if (hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory port control
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_res       = r_res;
        o_ram_re    = (accept && (i_req.req_type == REQ_RECORD)) || issue;
        o_ram_raddr = (r_state == S_IDLE) ? rec_bkt : r_addr[ADDR_W-1:0];
        o_ram_we    = (r_state == S_REC);
        o_ram_waddr = r_bkt;
        // saturating increment
        o_ram_wdata = (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1);
    end

    // datapath
    always_comb begin
        n_addr       = issue ? r_addr + CNT_W'(1) : r_addr;
        n_rd_vld     = issue;
        n_rd_idx     = r_addr[ADDR_W-1:0];
        n_rd_live    = r_valid_bits[o_ram_raddr];
        n_valid_bits = r_valid_bits;
        n_bkt        = r_bkt;
        n_num        = r_num;
        n_den        = r_den;
        n_total      = r_total;
        n_cum        = r_cum;
        n_cum_vld    = (r_state == S_WALK) && r_rd_vld;
        n_cum_idx    = r_rd_idx;
        n_prod       = PROD_W'(r_cum) * PROD_W'(r_den);
        n_prod_vld   = (r_state == S_WALK) && r_cum_vld;
        n_prod_idx   = r_cum_idx;
        n_target     = r_target;
        n_res        = r_res;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_bkt   = rec_bkt;
                    n_num   = i_req.frac_num;
                    n_den   = i_req.frac_den;
                    n_addr  = '0;
                    n_total = '0;
                end
            end
            S_REC: begin
                n_valid_bits[r_bkt]  = 1'b1;
                n_res.bucket_index   = BKT_W'(r_bkt);
                n_res.percentile_us  = '0;
            end
            S_SUM: begin
                if (r_rd_vld) begin
                    n_total = r_total + TOT_W'(rd_count);
                end
            end
            S_MUL: begin
                n_target           = PROD_W'(r_total) * PROD_W'(r_num);
                n_addr             = '0;
                n_cum              = '0;
                n_res.bucket_index = '0;
                // empty histogram answers zero; unreachable target the last bound
                n_res.percentile_us = (r_total == '0) ? '0 : bucket_bound(BKT_W'(LAST_ADDR));
            end
            S_WALK: begin
                if (r_rd_vld) begin
                    n_cum = r_cum + TOT_W'(rd_count);
                end
                if (hit) begin
                    n_res.percentile_us = bucket_bound(BKT_W'(r_prod_idx));
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_cum_vld    <= 1'b0;
            r_prod_vld   <= 1'b0;
            r_valid_bits <= '0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_rd_vld     <= n_rd_vld;
            r_cum_vld    <= n_cum_vld;
            r_prod_vld   <= n_prod_vld;
            r_valid_bits <= n_valid_bits;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_rd_live  <= n_rd_live;
        r_bkt      <= n_bkt;
        r_num      <= n_num;
        r_den      <= n_den;
        r_total    <= n_total;
        r_cum      <= n_cum;
        r_cum_idx  <= n_cum_idx;
        r_prod     <= n_prod;
        r_prod_idx <= n_prod_idx;
        r_target   <= n_target;
        r_res      <= n_res;
    end

`ifndef NO_ASSERTIONS
    // a record goes straight to the write-back cycle
    a_rec_writeback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.req_type == REQ_RECORD)) |=> (r_state == S_REC && o_ram_we))
        else $error("record not followed by counter write-back");

    // the walk never accumulates more than the total
    a_cum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cum <= r_total))
        else $error("cumulative count exceeds total");

    // the last bucket always reaches the target
    a_last_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_prod_vld && r_prod_idx == LAST_ADDR) |-> hit)
        else $error("walk passed the last bucket without a hit");

    // a word carries a bucket index or a percentile, never both
    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.percentile_us != '0)) |-> (o_res.bucket_index == '0))
        else $error("result carries both bucket index and percentile");

    // written-entry flags only ever get set
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_valid_bits & $past(r_valid_bits)) == $past(r_valid_bits)))
        else $error("counter valid flag cleared outside reset");
`endif

endmodule

FILE: rtl/latency_histogram_percentile.sv
// ----------------------------------------------------------------------------
// latency_histogram_percentile
// Twelve-bucket latency histogram with percentile estimate.
// ----------------------------------------------------------------------------
// Input stream (s_axis): one word per request. tuser selects the kind:
// record a latency sample, or query a percentile frac_num/frac_den.
// Output stream (m_axis): exactly one word per request, in order. A record
// returns the bucket it landed in; a query returns the upper bound in
// microseconds of the first bucket whose cumulative count reaches
// ceil(total*num/den), or zero when the histogram is empty.
// Counters sit in a 12-entry RAM with registered read. One request
// is in flight at a time. A record is a read-modify-write of its counter.
// A query sweeps the RAM twice, once for the total and once for the
// cumulative walk through a multiply stage, which stops at the answering
// bucket. An empty histogram answers zero; a zero denominator or a fraction
// above one skips the walk and answers the last bucket's bound.
// A result register sits on the output, so the next request is taken while
// a result waits; a stalled receiver holds the engine in its final state
// once that register is full. Reset clears all counters at once.
// ----------------------------------------------------------------------------
module latency_histogram_percentile import lhp_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // latency_us, frac_num, frac_den
    input  logic [0:0]             s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // bucket_index, percentile_us, zero pad
);

    localparam int ADDR_W = $clog2(NUM_BUCKETS);

    t_req                  req;
    t_result               res;
    logic                  res_valid;
    logic                  res_ready;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic                  r_m_valid, n_m_valid;
    t_result               r_m_res, n_m_res;

    // unpack the input word
    always_comb begin
        req.req_type   = t_req_type'(s_axis_tuser[0]);
        req.latency_us = s_axis_tdata[LAT_W-1:0];
        req.frac_num   = s_axis_tdata[LAT_W+FRAC_W-1:LAT_W];
        req.frac_den   = s_axis_tdata[LAT_W+2*FRAC_W-1:LAT_W+FRAC_W];
    end

    lhp_engine #(
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    lhp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BUCKETS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register: loads when empty or draining
    assign res_ready = !r_m_valid || m_axis_tready;

    always_comb begin
        n_m_valid = r_m_valid;
        n_m_res   = r_m_res;
        if (res_valid && res_ready) begin
            n_m_valid = 1'b1;
            n_m_res   = res;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_res <= n_m_res;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_m_res.percentile_us, r_m_res.bucket_index});

endmodule

FILE: test/lhp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhp_checker
// Watches both streams of the latency histogram, keeps its own copy of the
// bucket counters, predicts one result word per accepted request and checks
// every result word against the oldest prediction still owed.
// ----------------------------------------------------------------------------
module lhp_checker import lhp_pkg::*; #(
    parameter int COUNT_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,    // latency_us, frac_num, frac_den
    input  logic [0:0]             i_s_tuser,    // req_type
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,    // bucket_index, percentile_us, zero pad
    output int                     o_err_count,
    output int                     o_outstanding
);

    // bucket upper bounds in microseconds, bucket 0 in the low slice
    localparam logic [NUM_BUCKETS*PCT_W-1:0] BOUND_TABLE = {
        17'd100001, 17'd100000, 17'd50000, 17'd25000, 17'd10000, 17'd5000,
        17'd2500,   17'd1000,   17'd500,   17'd250,   17'd100,   17'd50
    };

    logic [COUNT_BITS-1:0] bin_count [NUM_BUCKETS];
    t_result               owed_results [$];
    int                    err_total = 0;

    assign o_err_count = err_total;

    function automatic logic [PCT_W-1:0] bound_at(input int idx);
        return BOUND_TABLE[idx*PCT_W +: PCT_W];
    endfunction

    // first bucket whose bound is not exceeded; the top bucket takes the rest
    function automatic logic [BKT_W-1:0] bucket_for(input logic [LAT_W-1:0] lat);
        for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
            if (lat <= LAT_W'(bound_at(i))) begin
                return BKT_W'(i);
            end
        end
        return BKT_W'(NUM_BUCKETS - 1);
    endfunction

    // ceil(total*num/den) target, walked over the running sum; wide enough
    // that nothing wraps for counters of up to 104 bits
    function automatic logic [PCT_W-1:0] pct_estimate(input logic [FRAC_W-1:0] num,
                                                      input logic [FRAC_W-1:0] den);
        logic [127:0] total;
        logic [127:0] goal;
        logic [127:0] run_sum;
        logic         reachable;
        total = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            total += bin_count[i];
        end
        if (total == 0) begin
            return '0;
        end
        reachable = (den != 0) && (num <= den);
        goal      = '0;
        if (reachable) begin
            goal = (total * 128'(num) + 128'(den) - 128'd1) / 128'(den);
        end
        run_sum = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            run_sum += bin_count[i];
            if (reachable && run_sum >= goal) begin
                return bound_at(i);
            end
        end
        return bound_at(NUM_BUCKETS - 1);
    endfunction

    // one line per mismatch; printing stops after a while, counting does not
    task automatic report_mismatch(input string what, input longint unsigned got_v,
                                   input longint unsigned exp_v);
        if (err_total < 100) begin
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what,
                     got_v, exp_v);
        end
        err_total++;
    endtask

    // result side first: a request taken at this edge cannot answer at it
    always @(posedge i_clk) begin : watch
        t_req             rq;
        t_result          seen;
        t_result          want;
        logic [BKT_W-1:0] bin;
        if (!i_rst_n) begin
            foreach (bin_count[i]) bin_count[i] = '0;
            owed_results.delete();
            o_outstanding <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.bucket_index  = i_m_tdata[BKT_W-1:0];
                seen.percentile_us = i_m_tdata[BKT_W +: PCT_W];
                if (owed_results.size() == 0) begin
                    report_mismatch("result word with none owed", i_m_tdata, 0);
                end else begin
                    want = owed_results.pop_front();
                    if (seen.bucket_index != want.bucket_index) begin
                        report_mismatch("bucket_index", seen.bucket_index,
                                        want.bucket_index);
                    end
                    if (seen.percentile_us != want.percentile_us) begin
                        report_mismatch("percentile_us", seen.percentile_us,
                                        want.percentile_us);
                    end
                    if (i_m_tdata[OUT_TDATA_W-1:OUT_DATA_BITS] != '0) begin
                        report_mismatch("tdata pad bits",
                                        i_m_tdata[OUT_TDATA_W-1:OUT_DATA_BITS], 0);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                rq.req_type   = t_req_type'(i_s_tuser[0]);
                rq.latency_us = i_s_tdata[LAT_W-1:0];
                rq.frac_num   = i_s_tdata[LAT_W +: FRAC_W];
                rq.frac_den   = i_s_tdata[LAT_W+FRAC_W +: FRAC_W];
                want          = '0;
                if (rq.req_type == REQ_RECORD) begin
                    bin = bucket_for(rq.latency_us);
                    // counters stick at all ones
                    if (bin_count[bin] != '1) begin
                        bin_count[bin] = bin_count[bin] + 1'b1;
                    end
                    want.bucket_index = bin;
                end else begin
                    want.percentile_us = pct_estimate(rq.frac_num, rq.frac_den);
                end
                owed_results.push_back(want);
            end
            o_outstanding <= owed_results.size();
        end
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives record and query words into the latency histogram with random
// gaps and output stalls: a directed opening over bucket edges and odd
// fractions, a random bulk, a few queries after a full drain, and a random
// tail. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
    import lhp_pkg::*;

    // counter width of the block and the checker
    localparam int CNT_W        = 16;
    localparam int BULK_ITEMS   = 1500;
    localparam int TAIL_ITEMS   = 250;
    localparam int DRAIN_CYCLES = 40;
    // ~1.8k words, each with its busy time plus the longest gap and stall, times ~5
    localparam int CYCLE_LIMIT  = 1_500_000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // latency_us, frac_num, frac_den
    logic [0:0]             s_axis_tuser  = '0;   // req_type
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // bucket_index, percentile_us, zero pad

    int err_count;
    int outstanding;
    int cycle_cnt  = 0;
    int stall_left = 0;
    bit idle_on    = 1'b1;

    latency_histogram_percentile #(
        .COUNT_BITS (CNT_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lhp_checker #(
        .COUNT_BITS (CNT_W)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_err_count   (err_count),
        .o_outstanding (outstanding)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // receiver stalls
    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left    <= 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 20) begin
                stall_left <= idle_len();
            end
        end
    end

    // present one word, optionally after a gap, and hold it until taken
    task automatic send_req(input t_req_type kind, input logic [LAT_W-1:0] lat,
                            input logic [FRAC_W-1:0] num, input logic [FRAC_W-1:0] den);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {den, num, lat};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold off the sender until every owed result word is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // random word: samples cluster on bucket edges, fractions on the corners
    task automatic send_random();
        t_req_type        kind;
        logic [LAT_W-1:0] lat;
        int unsigned      num;
        int unsigned      den;
        int               sel;
        int               bkt;
        kind = ($urandom_range(0, 99) < 55) ? REQ_RECORD : REQ_QUERY;
        lat  = $urandom;
        num  = $urandom_range(0, 1000000);
        den  = $urandom_range(1, 1000000);
        sel  = $urandom_range(0, 99);
        if (kind == REQ_RECORD) begin
            if (sel < 60) begin
                bkt = $urandom_range(0, NUM_BUCKETS - 1);
                lat = LAT_W'(bucket_bound(BKT_W'(bkt))) + $urandom_range(0, 2) - 1;
            end else if (sel < 85) begin
                lat = $urandom_range(0, 120000);
            end else if (sel < 88) begin
                lat = '0;
            end
        end else begin
            if (sel < 10) begin
                den = $urandom_range(1, 10);
            end else if (sel < 12) begin
                den = 0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                num = 0;
            end else if (sel < 16) begin
                num = den;
            end else if (sel < 24) begin
                num = (den < 1000000) ? $urandom_range(den + 1, 1000000) : 1000000;
            end else begin
                num = $urandom_range(0, den);
            end
        end
        send_req(kind, lat, FRAC_W'(num), FRAC_W'(den));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // queries on an empty histogram
        send_req(REQ_QUERY, 32'd0, 20'd1, 20'd2);
        send_req(REQ_QUERY, 32'hFFFF_FFFF, 20'd5, 20'd0);
        // bucket edges and the extremes of the sample
        send_req(REQ_RECORD, 32'd0, 20'd0, 20'd1);
        for (int i = 0; i < NUM_BUCKETS; i++) begin
            send_req(REQ_RECORD, LAT_W'(bucket_bound(BKT_W'(i))), 20'hFFFFF, 20'hFFFFF);
        end
        send_req(REQ_RECORD, 32'd51, 20'd0, 20'd0);
        send_req(REQ_RECORD, 32'd100002, 20'd3, 20'd7);
        send_req(REQ_RECORD, 32'hFFFF_FFFF, 20'd1000000, 20'd1);
        // zero numerator, whole range, above one, zero denominator, middles
        send_req(REQ_QUERY, 32'd0, 20'd0, 20'd1000000);
        send_req(REQ_QUERY, 32'd0, 20'd1000000, 20'd1000000);
        send_req(REQ_QUERY, 32'd0, 20'd1000000, 20'd1);
        send_req(REQ_QUERY, 32'd0, 20'd7, 20'd0);
        send_req(REQ_QUERY, 32'd0, 20'd1, 20'd2);
        send_req(REQ_QUERY, 32'd0, 20'd999999, 20'd1000000);
        send_req(REQ_QUERY, 32'd0, 20'd1, 20'd1000000);

        // random bulk, with idle-free stretches and full drains now and then
        for (int k = 0; k < BULK_ITEMS; k++) begin
            idle_on = (k % 400) < 300;
            if (k % 250 == 125) begin
                wait_drained();
            end
            send_random();
        end

        // queries on a settled histogram after a full drain
        wait_drained();
        idle_on = 1'b1;
        send_req(REQ_QUERY, 32'd0, 20'd1, 20'd2);
        send_req(REQ_QUERY, 32'd0, 20'd1000000, 20'd1000000);
        send_req(REQ_QUERY, 32'd0, 20'd1, 20'd1000000);

        // random tail
        for (int k = 0; k < TAIL_ITEMS; k++) begin
            send_random();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lhp_pkg.sv
rtl/lhp_ram.sv
rtl/lhp_engine.sv
rtl/latency_histogram_percentile.sv
test/lhp_checker.sv
test/tb_top.sv
